### rtl/core/ldax_pkg.sv
// Shared constants and types for the LDA exchange potential cube-root block.
package ldax_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int COEF_FRAC  = 24;
  localparam int DATA_W     = 32;
  localparam int COEF_W     = 25;
  localparam int FLOOR_W    = 31;
  localparam int CFG_W      = 31;
  localparam int IDX_W      = 1;
  localparam int RHO_W      = 31;

  localparam int RAD_USED   = RHO_W + 2 * FRAC_BITS;
  localparam int ROOT_W     = (RAD_USED + 2) / 3;
  localparam int RAD_W      = 3 * ROOT_W;
  localparam int SQ_W       = 2 * ROOT_W;
  localparam int REM_W      = 2 * ROOT_W + 2;
  localparam int WORK_W     = 2 * ROOT_W + 5;
  localparam int PROD_W     = COEF_W + ROOT_W;
  localparam int MAG_W      = DATA_W + 1;

  localparam int PIPE_LAT   = ROOT_W + 3;
  localparam int FIFO_AW    = $clog2(PIPE_LAT + 1);
  localparam int FIFO_DEPTH = 2 ** FIFO_AW;
  localparam int CNT_W      = FIFO_AW + 1;

  localparam logic [COEF_W-1:0] COEF_RESET  = COEF_W'(16521280);
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = '0;
  localparam logic [MAG_W-1:0]  MAG_LIMIT   = MAG_W'(1) << (DATA_W - 1);

  typedef enum logic [IDX_W-1:0] {
    REG_COEF  = 1'b0,
    REG_FLOOR = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic              valid;
    logic              zero;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SQ_W-1:0]   sq;
  } cbrt_stage_t;

endpackage

### rtl/core/ldax_if.sv
// Stream interfaces for density samples and potential results.
interface ldax_density_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] density;

  modport source (output valid, output density, input ready);
  modport sink   (input valid, input density, output ready);
endinterface

interface ldax_potential_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] potential;

  modport source (output valid, output potential, input ready);
  modport sink   (input valid, input potential, output ready);
endinterface

### rtl/core/ldax_cbrt_cell.sv
// One cube-root cell: resolves one root bit from three radicand bits.
module ldax_cbrt_cell
  import ldax_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cbrt_stage_t up,
  output cbrt_stage_t down
);

  logic [2:0]        digit;
  logic [WORK_W-1:0] shifted;
  logic [WORK_W-1:0] trial;
  logic [WORK_W-1:0] diff;
  logic              take;

  always_comb begin
    digit   = up.rad[RAD_W-1 -: 3];
    shifted = {up.rem, digit};
    // 12*y^2 + 6*y + 1
    trial   = (WORK_W'(up.sq) << 3) + (WORK_W'(up.sq) << 2)
            + (WORK_W'(up.root) << 2) + (WORK_W'(up.root) << 1) + WORK_W'(1);
    diff    = shifted - trial;
    take    = shifted >= trial;
  end

  always_ff @(posedge clk) begin
    down.zero <= up.zero;
    down.rad  <= up.rad << 3;
    down.rem  <= take ? diff[REM_W-1:0] : shifted[REM_W-1:0];
    down.root <= {up.root[ROOT_W-2:0], take};
    down.sq   <= take ? (up.sq << 2) + (SQ_W'(up.root) << 2) + SQ_W'(1)
                      : (up.sq << 2);
    if (rst) begin
      down.valid <= 1'b0;
    end else begin
      down.valid <= up.valid;
    end
  end

endmodule

### rtl/core/ldax_fifo.sv
// Result queue between the arithmetic pipeline and the output channel.
module ldax_fifo
  import ldax_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  output logic [DATA_W-1:0] rd_data,
  output logic              not_empty
);

  logic [DATA_W-1:0]  mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW-1:0] rd_ptr_next;
  logic [CNT_W-1:0]   fill;

  assign rd_ptr_next = rd_en ? rd_ptr + FIFO_AW'(1) : rd_ptr;

  // head register tracks mem[rd_ptr]; a write to the new head address bypasses
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
    rd_data <= (wr_en && wr_ptr == rd_ptr_next) ? wr_data : mem[rd_ptr_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      rd_ptr <= rd_ptr_next;
      fill   <= fill + CNT_W'(wr_en) - CNT_W'(rd_en);
    end
  end

  assign not_empty = fill != '0;

endmodule

### rtl/core/lda_exchange_potential_cbrt.sv
// Top level: LDA exchange potential, -coefficient * cbrt(density), Q7.24.
//
// sample carries one signed Q7.24 density per transaction; result returns
// one signed Q7.24 potential per transaction, in order. Negative densities
// clamp to zero, and a density at or below density_floor gives zero.
// cfg_we/cfg_index/cfg_data write exchange_coefficient (index 0, Q1.24)
// or density_floor (index 1); write only while no transaction is in flight.
//
// Pipeline: one input register, a chain of ROOT_W cube-root cells that each
// settle one root bit, one multiply register, and the result queue write.
// Throughput is one transaction per cycle while sample.ready is high. A
// credit counter covers the queue depth, so sample.ready stays high while
// the receiver keeps up and drops only when FIFO_DEPTH transactions are
// accepted but not yet delivered.
// Reset empties the pipeline and queue and restores both registers
// (coefficient cbrt(3/pi), floor zero).
module lda_exchange_potential_cbrt
  import ldax_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  ldax_density_if.sink     sample,
  ldax_potential_if.source result,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  logic [COEF_W-1:0]  exchange_coefficient;
  logic [FLOOR_W-1:0] density_floor;
  logic [CNT_W-1:0]   credit;
  logic               in_acc;
  logic               out_acc;
  logic [RHO_W-1:0]   rho;

  cbrt_stage_t        chain [ROOT_W+1];

  logic               mul_valid;
  logic               mul_zero;
  logic [PROD_W-1:0]  prod;
  logic [MAG_W-1:0]   mag;
  logic [MAG_W-1:0]   mag_sat;
  logic [MAG_W-1:0]   neg;
  logic [DATA_W-1:0]  pot;
  logic [DATA_W-1:0]  rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      exchange_coefficient <= COEF_RESET;
      density_floor        <= FLOOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEF:  exchange_coefficient <= cfg_data[COEF_W-1:0];
        REG_FLOOR: density_floor        <= cfg_data[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_acc       = sample.valid & sample.ready;
  assign out_acc      = result.valid & result.ready;
  assign sample.ready = credit < CNT_W'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      credit <= credit + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  assign rho = sample.density[DATA_W-1] ? '0 : sample.density[RHO_W-1:0];

  always_ff @(posedge clk) begin
    chain[0].zero <= rho <= density_floor;
    chain[0].rad  <= RAD_W'(rho) << (2 * FRAC_BITS);
    chain[0].rem  <= '0;
    chain[0].root <= '0;
    chain[0].sq   <= '0;
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else begin
      chain[0].valid <= in_acc;
    end
  end

  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    ldax_cbrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .up   (chain[i]),
      .down (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    mul_zero <= chain[ROOT_W].zero;
    prod     <= PROD_W'(exchange_coefficient) * PROD_W'(chain[ROOT_W].root);
    if (rst) begin
      mul_valid <= 1'b0;
    end else begin
      mul_valid <= chain[ROOT_W].valid;
    end
  end

  always_comb begin
    mag     = MAG_W'(prod >> COEF_FRAC);
    mag_sat = (mag > MAG_LIMIT) ? MAG_LIMIT : mag;
    neg     = '0 - mag_sat;
    pot     = mul_zero ? '0 : neg[DATA_W-1:0];
  end

  ldax_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (mul_valid),
    .wr_data   (pot),
    .rd_en     (out_acc),
    .rd_data   (rd_data),
    .not_empty (result.valid)
  );

  assign result.potential = $signed(rd_data);

endmodule

### rtl/core/ldax_checker.sv
// Port-level checks for the exchange potential block, bound to the top level.
module ldax_checker (
  input logic               clk,
  input logic               rst,
  input logic               sample_ready,
  input logic               result_valid,
  input logic               result_ready,
  input logic signed [31:0] potential
);

  a_never_positive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (potential[31] || potential == 32'sd0))
    else $error("positive potential on result channel");

  a_full_means_pending: assert property (@(posedge clk) disable iff (rst)
    !sample_ready |-> result_valid)
    else $error("input stalled with no result waiting");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(potential)))
    else $error("stalled result transaction changed");

endmodule

bind lda_exchange_potential_cbrt ldax_checker u_ldax_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_ready (sample.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .potential    (result.potential)
);
